FILE: design/fsr_pkg.sv
`timescale 1ns / 1ps

package fsr_pkg;

  localparam logic [7:0] SYNC_FIRST       = 8'hFF;
  localparam logic [7:0] SYNC_SECOND      = 8'h55;
  localparam logic [5:0] MAX_LENGTH_RESET = 6'd32;

  // frame parser phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // readout sequencer
  typedef enum logic [2:0] {
    RD_IDLE  = 3'b001,
    RD_LOAD  = 3'b010,
    RD_EMPTY = 3'b100
  } rd_state_t;

  // verified frame handed from parser to readout
  typedef struct packed {
    logic       start;
    logic [5:0] length;
  } frame_done_t;

endpackage

FILE: design/framed_serial_receiver.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_stall    rx_byte
// output    out_valid / out_stall  payload_byte, byte_index, message_length,
//                                  is_last, is_empty
// config    cfg_valid / cfg_ready  cfg_data (max_length)
//
// A received byte is taken while no verified message is being read out.
// A good checksum starts readout from the payload RAM: one result per cycle when
// out_stall is low (the single RAM read port sets this), input stalled until the
// last result reaches the output register. An empty message yields one result.
// rst is synchronous; it resets max_length to 32 and restarts the sync hunt.
// RAM contents are not cleared.

module framed_serial_receiver
  import fsr_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic [4:0] byte_index,
  output logic [5:0] message_length,
  output logic       is_last,
  output logic       is_empty
);

  localparam int AW = BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1;

  logic [5:0]    max_length;
  logic          accept;
  logic          busy;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  frame_done_t   done;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  fsr_rx #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_rx (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .max_length(max_length),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .done      (done)
  );

  fsr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(rx_byte),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fsr_drain #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_drain (
    .clk           (clk),
    .rst           (rst),
    .done          (done),
    .busy          (busy),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .message_length(message_length),
    .is_last       (is_last),
    .is_empty      (is_empty)
  );

endmodule

FILE: design/fsr_ram.sv
`timescale 1ns / 1ps

module fsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/fsr_rx.sv
`timescale 1ns / 1ps

module fsr_rx
  import fsr_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          accept,
  input  logic [7:0]                                    rx_byte,
  input  logic [5:0]                                    max_length,
  output logic                                          mem_we,
  output logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] mem_waddr,
  output frame_done_t                                   done
);

  localparam int AW = BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1;
  localparam logic [7:0] DEPTH_LIMIT = 8'(BUF_DEPTH);

  phase_t     phase, phase_next;
  logic [7:0] prev_byte, prev_byte_next;
  logic [5:0] exp_len, exp_len_next;
  logic [5:0] fill_count, fill_count_next;
  logic [7:0] sum, sum_next;
  logic [7:0] limit;
  logic [7:0] check;

  assign limit = ({2'b00, max_length} < DEPTH_LIMIT) ? {2'b00, max_length} : DEPTH_LIMIT;
  assign check = sum + rx_byte;
  assign mem_waddr = fill_count[AW-1:0];

  always_comb begin
    phase_next      = phase;
    prev_byte_next  = prev_byte;
    exp_len_next    = exp_len;
    fill_count_next = fill_count;
    sum_next        = sum;
    mem_we          = 1'b0;
    done.start      = 1'b0;
    done.length     = exp_len;
    if (accept) begin
      case (phase)
        PH_LEN: begin
          if (rx_byte > limit) begin
            phase_next      = PH_HUNT;
            prev_byte_next  = 8'h00;
            exp_len_next    = 6'd0;
            fill_count_next = 6'd0;
            sum_next        = 8'h00;
          end else begin
            phase_next      = PH_DATA;
            exp_len_next    = rx_byte[5:0];
            fill_count_next = 6'd0;
            sum_next        = rx_byte;
          end
        end
        PH_DATA: begin
          if (fill_count < exp_len) begin
            mem_we          = 1'b1;
            fill_count_next = fill_count + 6'd1;
            sum_next        = check;
          end else begin
            // checksum byte: frame is good when it brings the sum to zero
            done.start      = (check == 8'h00);
            phase_next      = PH_HUNT;
            prev_byte_next  = 8'h00;
            exp_len_next    = 6'd0;
            fill_count_next = 6'd0;
            sum_next        = 8'h00;
          end
        end
        default: begin
          if (prev_byte == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
            phase_next = PH_LEN;
          end else begin
            phase_next = PH_HUNT;
          end
          prev_byte_next = rx_byte;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      prev_byte  <= 8'h00;
      exp_len    <= 6'd0;
      fill_count <= 6'd0;
      sum        <= 8'h00;
    end else begin
      phase      <= phase_next;
      prev_byte  <= prev_byte_next;
      exp_len    <= exp_len_next;
      fill_count <= fill_count_next;
      sum        <= sum_next;
    end
  end

endmodule

FILE: design/fsr_drain.sv
`timescale 1ns / 1ps

module fsr_drain
  import fsr_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  frame_done_t                                   done,
  output logic                                          busy,
  output logic                                          mem_re,
  output logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] mem_raddr,
  input  logic [7:0]                                    mem_rdata,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic [7:0]                                    payload_byte,
  output logic [4:0]                                    byte_index,
  output logic [5:0]                                    message_length,
  output logic                                          is_last,
  output logic                                          is_empty
);

  localparam int AW = BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1;

  rd_state_t  state, state_next;
  logic [5:0] idx, idx_next;
  logic [5:0] len;
  logic [5:0] idx_inc;
  logic       out_free;
  logic       last_hit;
  logic       load_data;
  logic       load_empty;
  logic       out_valid_next;

  assign idx_inc  = idx + 6'd1;
  assign last_hit = (idx_inc == len);
  assign out_free = !out_valid || !out_stall;
  assign busy     = (state != RD_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    mem_re     = 1'b0;
    mem_raddr  = idx[AW-1:0];
    load_data  = 1'b0;
    load_empty = 1'b0;
    case (state)
      RD_IDLE: begin
        if (done.start) begin
          idx_next = 6'd0;
          if (done.length == 6'd0) begin
            state_next = RD_EMPTY;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = '0;
            state_next = RD_LOAD;
          end
        end
      end
      RD_LOAD: begin
        // read data stays put until the next read, so a stall just waits here
        if (out_free) begin
          load_data = 1'b1;
          if (last_hit) begin
            state_next = RD_IDLE;
          end else begin
            idx_next  = idx_inc;
            mem_re    = 1'b1;
            mem_raddr = idx_inc[AW-1:0];
          end
        end
      end
      RD_EMPTY: begin
        if (out_free) begin
          load_empty = 1'b1;
          state_next = RD_IDLE;
        end
      end
      default: begin
        state_next = RD_IDLE;
      end
    endcase
  end

  assign out_valid_next = (load_data || load_empty) ? 1'b1 :
                          (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RD_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (state == RD_IDLE && done.start) begin
      len <= done.length;
    end
    if (load_data) begin
      payload_byte   <= mem_rdata;
      byte_index     <= idx[4:0];
      message_length <= len;
      is_last        <= last_hit;
      is_empty       <= 1'b0;
    end else if (load_empty) begin
      payload_byte   <= 8'h00;
      byte_index     <= 5'd0;
      message_length <= 6'd0;
      is_last        <= 1'b1;
      is_empty       <= 1'b1;
    end
  end

endmodule

FILE: tb/framed_serial_receiver_tb.sv
`timescale 1ns / 1ps

module framed_serial_receiver_tb;
  import fsr_pkg::*;

  localparam int DEPTH        = 32;
  localparam int TOTAL_BYTES  = 320;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_LIMITS   = 7;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] index;
    logic [5:0] length;
    logic       last;
    logic       empty;
  } msg_byte_t;

  // Tracks the frame parser and holds the payload bytes a verified frame will release.
  class frame_scoreboard;
    bit [5:0]  max_length;
    phase_t    phase;
    bit [7:0]  prev_byte;
    bit [5:0]  want_len;
    bit [5:0]  fill;
    bit [7:0]  sum;
    bit [7:0]  store [DEPTH];
    msg_byte_t msg_q [$];
    int        errors;

    function new();
      max_length = MAX_LENGTH_RESET;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_HUNT;
      prev_byte = '0;
      want_len  = '0;
      fill      = '0;
      sum       = '0;
    endfunction

    function void set_limit(bit [5:0] v);
      max_length = v;
    endfunction

    function int pending();
      return msg_q.size();
    endfunction

    function void note_byte(bit [7:0] b);
      int        lim;
      int        i;
      bit [7:0]  total;
      msg_byte_t m;
      case (phase)
        PH_LEN: begin
          lim = (max_length < DEPTH) ? max_length : DEPTH;
          if (b > lim) begin
            restart();
          end else begin
            want_len = b[5:0];
            fill     = '0;
            sum      = b;
            phase    = PH_DATA;
          end
        end
        PH_DATA: begin
          if (fill < want_len) begin
            store[fill] = b;
            fill++;
            sum += b;
          end else begin
            total = sum + b;
            if (total == 8'd0) begin
              if (want_len == 0) begin
                m = '{data: 8'd0, index: 5'd0, length: 6'd0, last: 1'b1, empty: 1'b1};
                msg_q.push_back(m);
              end else begin
                for (i = 0; i < want_len; i++) begin
                  m.data   = store[i];
                  m.index  = i[4:0];
                  m.length = want_len;
                  m.last   = (i + 1 == want_len);
                  m.empty  = 1'b0;
                  msg_q.push_back(m);
                end
              end
            end
            restart();
          end
        end
        default: begin
          // hunting; an FF followed by 55 is the sync pair
          phase     = (prev_byte == SYNC_FIRST && b == SYNC_SECOND) ? PH_LEN : PH_HUNT;
          prev_byte = b;
        end
      endcase
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(msg_byte_t got);
      msg_byte_t want;
      if (msg_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %0d index %0d len %0d",
                 $time, got.data, got.index, got.length);
        return;
      end
      want = msg_q.pop_front();
      field_check("payload_byte", want.data, got.data);
      field_check("byte_index", want.index, got.index);
      field_check("message_length", want.length, got.length);
      field_check("is_last", want.last, got.last);
      field_check("is_empty", want.empty, got.empty);
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;
  logic [5:0] message_length;
  logic       is_last;
  logic       is_empty;

  frame_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              bytes_sent = 0;

  framed_serial_receiver #(
    .BUF_DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .message_length(message_length),
    .is_last       (is_last),
    .is_empty      (is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one block so input, config and output are seen in a fixed order per edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall) begin
        sb.check_result('{data: payload_byte, index: byte_index, length: message_length,
                          last: is_last, empty: is_empty});
      end
    end
  end

  // result backpressure in bursts
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_byte(input bit [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input bit [5:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // optional noise, then sync, length, payload and checksum; some frames are dropped or corrupted
  task automatic send_frame(input int lim);
    int       pick;
    int       i;
    bit [7:0] len_byte;
    bit [7:0] sum;
    bit [7:0] b;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) len_byte = lim[7:0];
    else if (pick == 1) len_byte = 8'd0;
    else if (pick == 2) len_byte = 8'($urandom_range(lim + 1, 255));
    else len_byte = 8'($urandom_range(0, lim));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(len_byte);
    if (len_byte > lim) return;
    sum = len_byte;
    for (i = 0; i < len_byte; i++) begin
      b = 8'($urandom);
      send_byte(b);
      sum += b;
    end
    if ($urandom_range(0, 6) == 0) send_byte(8'(-sum + $urandom_range(1, 255)));
    else send_byte(-sum);
  endtask

  initial begin
    bit [7:0] opening [] = '{
      8'hFF, 8'h55, 8'h00, 8'h00,                 // empty message
      8'hFF, 8'hFF, 8'h55, 8'h01, 8'h80, 8'h7F,   // repeated FF before 55
      8'hFF, 8'h55, 8'h02, 8'hFF, 8'h55, 8'hAA,   // sync pair inside payload
      8'hFF, 8'h55, 8'h01, 8'h00, 8'h00,          // bad checksum
      8'hFF, 8'h55, 8'h21                         // length above limit
    };
    bit [5:0] limits [NUM_LIMITS] = '{6'd0, 6'd63, 6'd1, 6'd33, 6'd7, 6'd0, 6'd32};
    int       lim;
    int       p;
    int       i;

    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < opening.size(); i++) send_byte(opening[i]);

    limits[5] = 6'($urandom_range(0, 63));
    for (p = 0; p < NUM_LIMITS; p++) begin
      wait_drained();
      write_max_length(limits[p]);
      lim   = (limits[p] < DEPTH) ? limits[p] : DEPTH;
      quiet = (p == NUM_LIMITS - 1);
      while (bytes_sent < opening.size() + (p + 1) * TOTAL_BYTES / NUM_LIMITS) send_frame(lim);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
design/fsr_pkg.sv
design/fsr_ram.sv
design/fsr_rx.sv
design/fsr_drain.sv
design/framed_serial_receiver.sv
tb/framed_serial_receiver_tb.sv
